### rtl/nws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nws_pkg;

  // Field and datapath widths.
  localparam int unsigned DATA_W  = 16;           // Q4.12 operands and bias
  localparam int unsigned PROD_W  = 2 * DATA_W;   // Q8.24 product
  localparam int unsigned ACC_W   = 40;           // Q16.24 accumulator
  localparam int unsigned SUM_W   = ACC_W + 2;    // headroom for acc + product + bias
  localparam int unsigned BIAS_SH = 12;           // Q4.12 to Q8.24 alignment
  localparam int unsigned ACT_W   = 16;           // unsigned Q0.16 activation

  // Sigmoid table geometry. The argument window [-8,8) in Q8.24 spans 2^28 codes.
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned DEPTH_W     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OFF_W       = 28;

  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = SUM_W'(-(64'sd1 <<< (ACC_W - 1)));
  // Limits on the sum itself: twice the sum must stay inside [-8,8).
  localparam logic signed [ACC_W-1:0] HALF_LIM = ACC_W'(64'sd1 <<< (OFF_W - 2));

  typedef logic [ACT_W-1:0] rom_t [TABLE_DEPTH];

  // Unsigned long division by shift and subtract; only used while the table is
  // built at elaboration.
  function automatic longint unsigned div_u64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned rem;
    int              i;
    q   = 64'd0;
    rem = 64'd0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= b) begin
        rem  = rem - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Builds the sigmoid table at elaboration. Entry k is sampled at the left edge
  // of its bin, x = -8 + 16*k/TABLE_DEPTH, and holds 65536/(1+exp(-x)) rounded
  // half up. exp is evaluated as a Taylor series in Q.32 with truncating steps.
  function automatic rom_t build_rom();
    rom_t               r;
    int                 k;
    int                 n;
    longint             p;
    longint unsigned    ap;
    longint unsigned    term;
    longint unsigned    e;
    longint unsigned    num;
    longint unsigned    den;
    longint unsigned    val;
    longint unsigned    one_q32;
    one_q32 = 64'd1 << 32;
    for (k = 0; k < int'(TABLE_DEPTH); k++) begin
      p    = 64'(16 * k) - 64'(8 * TABLE_DEPTH);
      ap   = (p < 0) ? 64'(-p) : 64'(p);
      term = one_q32;
      e    = one_q32;
      n    = 1;
      while ((n < 200) && (term != 64'd0)) begin
        term = div_u64(term * ap, 64'(TABLE_DEPTH) * 64'(n));
        e    = e + term;
        n    = n + 1;
      end
      num = (p >= 0) ? e : one_q32;
      den = one_q32 + e;
      val = div_u64((num << 16) + (den >> 1), den);
      if (val > 64'd65535) begin
        val = 64'd65535;
      end
      r[k] = val[ACT_W-1:0];
    end
    return r;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

endpackage

`default_nettype wire

### rtl/neuron_weighted_sum_sigmoid_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Perceptron neuron with a sigmoid activation.
// Input channel (in_valid/in_ready): one item is an input activation, its weight,
// both signed Q4.12, and a flag that marks the final input of the neuron. Each
// item's product is added into a saturating 40-bit Q16.24 accumulator.
// Output channel (out_valid/out_ready): on the final item the bias is added once,
// and one result carries the saturated weighted sum (Q16.24) and the sigmoid of
// twice that sum (unsigned Q0.16, from a constant table). Items not marked final
// give no result. The accumulator then clears for the next neuron.
// Throughput: one item per cycle while in_ready is high. A final item passes
// through the four registers of the path: multiplier, accumulator, table index
// and table read with output. The bias is written through cfg_we/cfg_wdata; the
// user must do so only while the block is idle; the block does not enforce it.
// Reset (rst_n low, synchronous) empties the pipeline, clears the accumulator and
// sets the bias to zero. When the receiver stalls, the result holds in the output
// register while the stages behind it keep filling; in_ready falls only once a
// final item can no longer move forward, and non-final items keep accumulating.
module neuron_weighted_sum_sigmoid_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_we,
  input  wire logic signed [nws_pkg::DATA_W-1:0]      cfg_wdata,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [nws_pkg::DATA_W-1:0]      in_input_value,
  input  wire logic signed [nws_pkg::DATA_W-1:0]      in_weight,
  input  wire logic                                   in_last_input,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [nws_pkg::ACC_W-1:0]            out_weighted_sum,
  output logic        [nws_pkg::ACT_W-1:0]            out_activation
);

  // Bias register.
  logic signed [nws_pkg::DATA_W-1:0] bias_r;

  // Stage 1: product of the accepted pair.
  logic                              v1_r;
  logic                              last1_r;
  logic signed [nws_pkg::PROD_W-1:0] prod_r;

  // Stage 2: accumulator and the finished sum of a neuron.
  logic signed [nws_pkg::ACC_W-1:0]  acc_r;
  logic signed [nws_pkg::ACC_W-1:0]  acc_nxt;
  logic                              v2_r;
  logic signed [nws_pkg::ACC_W-1:0]  sum2_r;

  // Stage 3: table index.
  logic                              v3_r;
  logic signed [nws_pkg::ACC_W-1:0]  sum3_r;
  logic        [nws_pkg::IDX_W-1:0]  idx3_r;
  logic        [nws_pkg::IDX_W-1:0]  idx_nxt;

  // Stage 4: output register.
  logic                              out_valid_r;
  logic signed [nws_pkg::ACC_W-1:0]  out_sum_r;
  logic        [nws_pkg::ACT_W-1:0]  out_act_r;

  // Flow control. Only final items need room further down; the others are
  // absorbed by the accumulator.
  logic in_acc;
  logic s1_take;
  logic rdy2;
  logic rdy3;
  logic rdy4;
  logic adv3;
  logic adv4;

  assign rdy4     = !out_valid_r || out_ready;
  assign adv4     = v3_r && rdy4;
  assign rdy3     = !v3_r || rdy4;
  assign adv3     = v2_r && rdy3;
  assign rdy2     = !v2_r || rdy3;
  assign s1_take  = v1_r && (!last1_r || rdy2);
  assign in_ready = !v1_r || s1_take;
  assign in_acc   = in_valid && in_ready;

  // One wide adder: the bias joins only on the final item, and the result is
  // saturated once.
  logic signed [nws_pkg::SUM_W-1:0] bias_term;
  logic signed [nws_pkg::SUM_W-1:0] sum_wide;
  logic signed [nws_pkg::ACC_W-1:0] sum_sat;

  always_comb begin
    bias_term = last1_r ? (nws_pkg::SUM_W'(bias_r) <<< nws_pkg::BIAS_SH) : '0;
    sum_wide  = nws_pkg::SUM_W'(acc_r) + nws_pkg::SUM_W'(prod_r) + bias_term;
    if (sum_wide > nws_pkg::ACC_MAX) begin
      sum_sat = nws_pkg::ACC_MAX[nws_pkg::ACC_W-1:0];
    end else if (sum_wide < nws_pkg::ACC_MIN) begin
      sum_sat = nws_pkg::ACC_MIN[nws_pkg::ACC_W-1:0];
    end else begin
      sum_sat = sum_wide[nws_pkg::ACC_W-1:0];
    end
    acc_nxt = last1_r ? '0 : sum_sat;
  end

  // Table index: twice the sum, clamped to [-8,8), offset by +8, then scaled to
  // the table depth. Below the window the index is zero, above it the last entry.
  logic [nws_pkg::OFF_W-1:0]                 off;
  logic [nws_pkg::OFF_W+nws_pkg::DEPTH_W-1:0] scaled;

  always_comb begin
    if (sum2_r >= nws_pkg::HALF_LIM) begin
      off = '1;
    end else if (sum2_r < -nws_pkg::HALF_LIM) begin
      off = '0;
    end else begin
      off = {sum2_r[nws_pkg::OFF_W-2:0], 1'b0}
          + (nws_pkg::OFF_W'(1) << (nws_pkg::OFF_W - 1));
    end
    scaled  = (nws_pkg::OFF_W + nws_pkg::DEPTH_W)'(off)
            * (nws_pkg::OFF_W + nws_pkg::DEPTH_W)'(nws_pkg::TABLE_DEPTH);
    idx_nxt = scaled[nws_pkg::OFF_W +: nws_pkg::IDX_W];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r      <= '0;
      acc_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        bias_r <= cfg_wdata;
      end
      if (s1_take) begin
        acc_r <= acc_nxt;
      end
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (s1_take) begin
        v1_r <= 1'b0;
      end
      if (s1_take && last1_r) begin
        v2_r <= 1'b1;
      end else if (adv3) begin
        v2_r <= 1'b0;
      end
      if (adv3) begin
        v3_r <= 1'b1;
      end else if (adv4) begin
        v3_r <= 1'b0;
      end
      if (adv4) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prod_r  <= nws_pkg::PROD_W'(in_input_value) * nws_pkg::PROD_W'(in_weight);
      last1_r <= in_last_input;
    end
    if (s1_take && last1_r) begin
      sum2_r <= sum_sat;
    end
    if (adv3) begin
      sum3_r <= sum2_r;
      idx3_r <= idx_nxt;
    end
    if (adv4) begin
      out_sum_r <= sum3_r;
      out_act_r <= nws_pkg::SIG_ROM[idx3_r];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_weighted_sum = out_sum_r;
  assign out_activation   = out_act_r;

  // The accumulator starts the next neuron from zero.
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && last1_r) |=> (acc_r == '0))
    else $error("accumulator not cleared after a final item");

  // The input side only stalls behind a held item while the receiver stalls.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v1_r && last1_r && out_valid_r && !out_ready))
    else $error("input stalled without a downstream stall");

  // A table index waiting for the output register is not disturbed.
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !adv4) |=> (v3_r && $stable(idx3_r) && $stable(sum3_r)))
    else $error("stage 3 lost or changed while stalled");

endmodule

`default_nettype wire
